FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the table unit checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/kelt_pkg.sv
// ----------------------------------------------------------------------------
// kelt_pkg
// Types and constants shared by the keyed latency average table.
// ----------------------------------------------------------------------------
`default_nettype none

package kelt_pkg;

    localparam int VAL_W = 64;
    localparam int KEY_W = 64;
    localparam int AVG_W = 27;
    localparam int CNT_W = 3;
    localparam int ST_W  = 3;

    localparam logic [VAL_W-1:0] CLIP_LOW  = 64'd2000000;
    localparam logic [VAL_W-1:0] CLIP_HIGH = 64'd128000000;
    localparam logic [CNT_W-1:0] COUNT_SAT = 3'd4;

    localparam logic [ST_W-1:0] ST_HIT      = 3'd0;
    localparam logic [ST_W-1:0] ST_MISS     = 3'd1;
    localparam logic [ST_W-1:0] ST_UPDATED  = 3'd2;
    localparam logic [ST_W-1:0] ST_INSERTED = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;
    localparam logic [ST_W-1:0] ST_ZERO     = 3'd5;

    // One command as it travels along the row of cells.
    typedef struct packed {
        logic             vld;   // beat present in this stage
        logic             note;  // 1 = note a sample, 0 = lookup
        logic             done;  // status already settled
        logic [ST_W-1:0]  st;    // settled status
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;   // result value so far
        logic [AVG_W-1:0] smp;   // clipped sample
    } t_beat;

endpackage

`default_nettype wire

FILE: rtl/core/kelt_front.sv
// ----------------------------------------------------------------------------
// kelt_front
// Input stage: decodes a command beat, clips the sample and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module kelt_front
    import kelt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic             i_note,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [VAL_W-1:0] i_value,
    output t_beat                 o_beat
);

    t_beat            r_beat;
    t_beat            n_beat;
    logic             w_zero;
    logic [VAL_W-1:0] w_clip;

    assign w_zero = (i_value == '0);

    always_comb begin
        priority if (i_value < CLIP_LOW) begin
            w_clip = CLIP_LOW;
        end else if (i_value > CLIP_HIGH) begin
            w_clip = CLIP_HIGH;
        end else begin
            w_clip = i_value;
        end
    end

    always_comb begin
        n_beat      = '0;
        n_beat.vld  = i_vld;
        n_beat.note = i_note;
        n_beat.key  = i_key;
        n_beat.smp  = w_clip[AVG_W-1:0];
        // Notes always report a zero value; a lookup carries its fallback.
        n_beat.val  = i_note ? '0 : i_value;
        // A zero sample settles at once and leaves the table untouched.
        n_beat.done = i_note && w_zero;
        n_beat.st   = ST_ZERO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

FILE: rtl/core/kelt_cell.sv
// ----------------------------------------------------------------------------
// kelt_cell
// One table entry: compares, updates or claims itself, and passes the beat on.
// ----------------------------------------------------------------------------
`default_nettype none

module kelt_cell
    import kelt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_beat i_beat,
    output t_beat      o_beat
);

    t_beat              r_beat;
    t_beat              n_beat;
    logic               r_occ;
    logic               n_occ;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   n_key;
    logic [AVG_W-1:0]   r_avg;
    logic [AVG_W-1:0]   n_avg;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               w_act;
    logic               w_hit;
    logic               w_young;
    logic [AVG_W:0]     w_sum;
    logic [AVG_W+3:0]   w_wsum;

    assign w_act   = i_beat.vld && !i_beat.done;
    assign w_hit   = r_occ && (i_beat.key == r_key);
    assign w_young = (r_cnt < COUNT_SAT);

    // (avg + s) / 2 and (7 * avg + s) / 8, both rounded down.
    assign w_sum  = {1'b0, r_avg} + {1'b0, i_beat.smp};
    assign w_wsum = ({1'b0, r_avg, 3'b000} - {4'b0000, r_avg}) + {4'b0000, i_beat.smp};

    always_comb begin
        n_beat = i_beat;
        n_occ  = r_occ;
        n_key  = r_key;
        n_avg  = r_avg;
        n_cnt  = r_cnt;
        if (w_act) begin
            priority if (w_hit) begin
                n_beat.done = 1'b1;
                if (i_beat.note) begin
                    n_beat.st = ST_UPDATED;
                    if (w_young) begin
                        n_avg = w_sum[AVG_W:1];
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_avg = w_wsum[AVG_W+2:3];
                    end
                end else begin
                    n_beat.st  = ST_HIT;
                    n_beat.val = {{(VAL_W-AVG_W){1'b0}}, r_avg};
                end
            end else if (!r_occ && i_beat.note) begin
                // Entries fill in order, so the first free cell takes the key.
                n_beat.done = 1'b1;
                n_beat.st   = ST_INSERTED;
                n_occ       = 1'b1;
                n_key       = i_beat.key;
                n_avg       = i_beat.smp;
                n_cnt       = CNT_W'(1);
            end else begin
                // Another key lives here, or a lookup meets a free cell:
                // the beat passes on unchanged.
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
            r_occ      <= 1'b0;
        end else if (i_en) begin
            r_beat <= n_beat;
            r_occ  <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_key <= n_key;
            r_avg <= n_avg;
            r_cnt <= n_cnt;
        end
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

FILE: rtl/core/keyed_ewma_latency_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_ewma_latency_table_unit
// Keyed table of latency averages built as a row of entry cells.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata                       tuser
//  s_axis    in   [63:0] key, [127:64] value   [0] command (0 lookup, 1 note)
//  m_axis    out  [63:0] result_value          [2:0] status
//
// Each command beat enters an input register and then walks the row of
// TABLE_DEPTH cells, one cell per cycle while the row is not stalled, before
// landing in the output register; a new beat is taken every cycle unless the
// row stalls, since each cell sees the commands in arrival order.
// The whole row advances on one enable; when the output register holds a
// result that is not taken, the row and the input side stall together.
// Reset clears the stage valid bits and the entry occupancy flags only.
//
`default_nettype none

module keyed_ewma_latency_table_unit
    import kelt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Slave side.
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,  // [63:0] key, [127:64] value
    input  wire logic [0:0]   i_s_axis_tuser,  // [0] command
    // Master side.
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [63:0]       o_m_axis_tdata,  // [63:0] result_value
    output logic [2:0]        o_m_axis_tuser   // [2:0] status
);

    // The row moves whenever the output register is free or being drained.
    logic            w_en;
    t_beat           w_beat [TABLE_DEPTH+1];
    t_beat           w_last;
    logic            r_out_vld;
    logic [VAL_W-1:0] r_out_val;
    logic [ST_W-1:0] r_out_st;
    logic [ST_W-1:0] n_out_st;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    kelt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_axis_tvalid),
        .i_note  (i_s_axis_tuser[0]),
        .i_key   (i_s_axis_tdata[63:0]),
        .i_value (i_s_axis_tdata[127:64]),
        .o_beat  (w_beat[0])
    );

    // Cell k holds entry k; occupied cells always form a prefix of the row.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        kelt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_beat  (w_beat[g]),
            .o_beat  (w_beat[g+1])
        );
    end

    assign w_last = w_beat[TABLE_DEPTH];

    // A beat that no cell settled is a lookup miss or a note on a full table.
    always_comb begin
        priority if (w_last.done) begin
            n_out_st = w_last.st;
        end else if (w_last.note) begin
            n_out_st = ST_FULL;
        end else begin
            n_out_st = ST_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_val <= w_last.val;
            r_out_st  <= n_out_st;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_val;
    assign o_m_axis_tuser  = r_out_st;

endmodule

`default_nettype wire

FILE: rtl/core/kelt_checker.sv
// ----------------------------------------------------------------------------
// kelt_checker
// Port-level assertions for the keyed latency average table, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kelt_checker
    import kelt_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic [127:0] i_s_axis_tdata,
    input wire logic [0:0]   i_s_axis_tuser,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [63:0]  o_m_axis_tdata,
    input wire logic [2:0]   o_m_axis_tuser
);

    logic w_note_st;
    logic w_in_beat;

    assign w_note_st = (o_m_axis_tuser == ST_UPDATED) || (o_m_axis_tuser == ST_INSERTED)
                    || (o_m_axis_tuser == ST_FULL) || (o_m_axis_tuser == ST_ZERO);
    assign w_in_beat = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata != '0)
                    && (i_s_axis_tuser != 1'b0);

    // A stalled result holds still.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))

    // Every note reports a zero value.
    `ASSERT_CLK(a_note_zero, i_clk, i_rst_n, (o_m_axis_tvalid && w_note_st) |-> (o_m_axis_tdata == '0))

    // Stored averages never leave the clipping window.
    `ASSERT_CLK(a_hit_range, i_clk, i_rst_n, (o_m_axis_tvalid && (o_m_axis_tuser == ST_HIT)) |-> ((o_m_axis_tdata >= CLIP_LOW) && (o_m_axis_tdata <= CLIP_HIGH)))

    // The row is a stall-together pipeline: ready follows the output side alone.
    `ASSERT_CLK(a_ready, i_clk, i_rst_n, (o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready)) || !w_in_beat)

    // No result is shown right after reset.
    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind keyed_ewma_latency_table_unit kelt_checker u_kelt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

FILE: tb/kelt_result_checker.sv
// ----------------------------------------------------------------------------
// kelt_result_checker
// Watches both stream channels of the latency average table, predicts
// every result from the accepted commands and compares it field by field.
// ----------------------------------------------------------------------------

module kelt_result_checker
    import kelt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,   // [63:0] key, [127:64] value
    input  logic [0:0]   i_s_tuser,   // [0] command
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [63:0]  i_m_tdata,   // [63:0] result_value
    input  logic [2:0]   i_m_tuser,   // [2:0] status
    output int           o_fail_count,
    output int           o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ST_W-1:0]  status;
    } t_table_result;

    // Own copy of the table contents.
    logic [KEY_W-1:0] table_keys   [TABLE_DEPTH];
    logic [AVG_W-1:0] table_avgs   [TABLE_DEPTH];
    logic [CNT_W-1:0] table_counts [TABLE_DEPTH];
    int               table_used;

    t_table_result    pending_results[$];
    int               pending_count;
    int               fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    initial begin
        table_used    = 0;
        fail_count    = 0;
        pending_count = 0;
    end

    // Applies one command to the table copy and returns the result it yields.
    task automatic update_table(input logic is_note, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] val,
                                output t_table_result res);
        int               idx;
        int               i;
        logic [VAL_W-1:0] smp;
        logic [VAL_W-1:0] avg;
        idx = -1;
        res.value = '0;
        for (i = 0; i < table_used; i++) begin
            if (idx < 0 && table_keys[i] == key) begin
                idx = i;
            end
        end
        if (!is_note) begin
            if (idx >= 0) begin
                res.value  = VAL_W'(table_avgs[idx]);
                res.status = ST_HIT;
            end else begin
                res.value  = val;
                res.status = ST_MISS;
            end
        end else if (val == '0) begin
            res.status = ST_ZERO;
        end else begin
            smp = val;
            if (smp < CLIP_LOW) begin
                smp = CLIP_LOW;
            end
            if (smp > CLIP_HIGH) begin
                smp = CLIP_HIGH;
            end
            if (idx >= 0) begin
                avg = VAL_W'(table_avgs[idx]);
                if (table_counts[idx] < COUNT_SAT) begin
                    avg = (avg + smp) >> 1;
                    table_counts[idx] = table_counts[idx] + 1'b1;
                end else begin
                    avg = (avg * 7 + smp) >> 3;
                end
                table_avgs[idx] = avg[AVG_W-1:0];
                res.status = ST_UPDATED;
            end else if (table_used >= TABLE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                table_keys[table_used]   = key;
                table_avgs[table_used]   = smp[AVG_W-1:0];
                table_counts[table_used] = CNT_W'(1);
                table_used++;
                res.status = ST_INSERTED;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_table_result exp_res;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                update_table(i_s_tuser[0], i_s_tdata[63:0], i_s_tdata[127:64], exp_res);
                pending_results.push_back(exp_res);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with no command outstanding, value %h status %0d",
                             $time, i_m_tdata, i_m_tuser);
                    fail_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (i_m_tdata !== exp_res.value) begin
                        $display("%0t: result_value mismatch, expected %h, actual %h",
                                 $time, exp_res.value, i_m_tdata);
                        fail_count++;
                    end
                    if (i_m_tuser !== exp_res.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, exp_res.status, i_m_tuser);
                        fail_count++;
                    end
                end
            end
            pending_count = pending_results.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the keyed latency average table: directed corner
// cases, then random lookups and notes on a key pool, with bursty input,
// a stalling receiver and long hold-offs that fill the cell row.
// ----------------------------------------------------------------------------

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import kelt_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    // A beat passes the input register, the TABLE_DEPTH cell registers and the output register.
    localparam int PIPE_LATENCY   = TABLE_DEPTH + 2;
    localparam int RANDOM_BEATS   = 1600;
    // The pool is a little larger than the table, so it fills up and the
    // keys left outside it keep hitting the full case.
    localparam int POOL_SIZE      = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_NOTE   = 1'b1
    } t_command;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;   // [63:0] key, [127:64] value
    logic [0:0]   s_tuser  = '0;   // [0] command
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;         // [63:0] result_value
    logic [2:0]   m_tuser;         // [2:0] status

    int           fail_count;
    int           pending;
    int           beats_sent = 0;
    int           idle_cycles = 0;
    logic [63:0]  key_pool[POOL_SIZE];

    always #1 i_clk = ~i_clk;

    keyed_ewma_latency_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    kelt_result_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Offers one command beat and returns at the edge where it is taken.
    // The valid stays high on return, so a following beat is not preceded
    // by a bubble unless the caller asks for a gap.
    task automatic send_command(input t_command cmd, input logic [63:0] key,
                                input logic [63:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {val, key};
        do @(posedge i_clk); while (!s_tready);
        beats_sent++;
    endtask

    // One random command. Most traffic targets the pool so that the table
    // fills, entries get updated past the saturation point and lookups hit;
    // the rest uses fresh keys and sample values outside the clip window.
    task automatic send_random_command();
        int          pick;
        logic [63:0] key;
        logic [63:0] val;
        pick = $urandom_range(99);
        key  = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (pick < 45) begin
            val = 64'($urandom_range(128000000, 2000000));
            send_command(CMD_NOTE, key, val);
        end else if (pick < 52) begin
            send_command(CMD_NOTE, key, rand_word());
        end else if (pick < 56) begin
            send_command(CMD_NOTE, key, 64'($urandom_range(400000000, 128000001)));
        end else if (pick < 61) begin
            send_command(CMD_NOTE, key, 64'($urandom_range(1999999, 1)));
        end else if (pick < 65) begin
            send_command(CMD_NOTE, key, 64'd0);
        end else if (pick < 92) begin
            send_command(CMD_LOOKUP, key, rand_word());
        end else if (pick < 96) begin
            send_command(CMD_LOOKUP, rand_word(), rand_word());
        end else begin
            send_command(CMD_NOTE, rand_word(), rand_word());
        end
    endtask

    // Receiver: changes its stall pattern at random intervals, from always
    // ready to mostly stalled. Twice, once enough beats have gone in,
    // it holds off for a long stretch while the sender keeps offering, so
    // the cell row fills and the input side has to stall.
    initial begin : receiver
        int mode;
        int mode_left;
        int holds_done;
        mode       = 0;
        mode_left  = 0;
        holds_done = 0;
        forever begin
            if ((holds_done == 0 && beats_sent >= 250) ||
                (holds_done == 1 && beats_sent >= 1000)) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(3);
                    mode_left = $urandom_range(80, 10);
                end
                mode_left--;
                case (mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= ($urandom_range(1) == 0);
                    end
                    2: begin
                        m_tready <= ($urandom_range(3) == 0);
                    end
                    default: begin
                        m_tready <= ($urandom_range(7) != 0);
                    end
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int          sent;
        int          burst_left;
        int          gap;
        logic [63:0] all_ones;
        all_ones = '1;
        key_pool[0] = '0;
        key_pool[1] = all_ones;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = rand_word();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, back to back. Empty table: a lookup misses and
        // returns its fallback unchanged.
        send_command(CMD_LOOKUP, key_pool[0], all_ones);
        // A zero sample is ignored and does not insert the key.
        send_command(CMD_NOTE, key_pool[0], 64'd0);
        send_command(CMD_LOOKUP, key_pool[0], 64'd0);
        // A tiny sample is clipped up to the floor on insertion.
        send_command(CMD_NOTE, key_pool[0], 64'd1);
        send_command(CMD_LOOKUP, key_pool[0], all_ones);
        // The largest sample is clipped down to the ceiling on insertion.
        send_command(CMD_NOTE, all_ones, all_ones);
        // Updates that halve while fewer than four samples are held, with
        // samples right at both clip limits and just below the floor.
        send_command(CMD_NOTE, all_ones, CLIP_HIGH);
        send_command(CMD_NOTE, all_ones, CLIP_LOW);
        send_command(CMD_NOTE, all_ones, CLIP_LOW - 1);
        // From here the sample count is saturated: 7/8 averaging.
        send_command(CMD_NOTE, all_ones, CLIP_HIGH + 1);
        send_command(CMD_NOTE, all_ones, 64'd5000000);
        send_command(CMD_NOTE, all_ones, 64'd5000001);
        send_command(CMD_LOOKUP, all_ones, 64'd0);
        // An unknown key misses, also after a zero note, until a real sample inserts it.
        send_command(CMD_LOOKUP, key_pool[2], rand_word());
        send_command(CMD_NOTE, key_pool[2], 64'd0);
        send_command(CMD_LOOKUP, key_pool[2], rand_word());
        send_command(CMD_NOTE, key_pool[2], 64'd16000000);
        send_command(CMD_LOOKUP, key_pool[2], 64'd0);

        // Random part in bursts with random gaps; a gap of zero keeps the
        // valid high so some bursts run together into long stretches.
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            burst_left = $urandom_range(24, 1);
            while (burst_left > 0 && sent < RANDOM_BEATS) begin
                send_random_command();
                burst_left--;
                sent++;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b0;

        // Drain: every result must come back; the watchdog catches a hang.
        // The extra cycles afterwards expose any result beat nobody asked for.
        while (pending != 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
